>>> rtl/core/configurable_crc_engine_defines.svh
// Assertion macros for the CRC engine RTL.
`ifndef CONFIGURABLE_CRC_ENGINE_DEFINES_SVH
`define CONFIGURABLE_CRC_ENGINE_DEFINES_SVH

// Checked at every rising clock edge, masked while reset is high.
`define CCE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define CCE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/core/cce_pkg.sv
package cce_pkg;

   // Register offsets inside the block
   localparam logic [3:0] OFS_CTRL = 4'd0;
   localparam logic [3:0] OFS_SEED = 4'd4;
   localparam logic [3:0] OFS_DATA = 4'd8;

   // Access kinds
   localparam logic MODE_READ  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // Access sizes (code three acts as a word)
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   // Polynomial selects (three acts as CRC-32)
   localparam logic [1:0] POLY_SEL_CCITT = 2'd0;
   localparam logic [1:0] POLY_SEL_CRC16 = 2'd1;

   localparam logic [31:0] POLY_CCITT = 32'h0000_1021;
   localparam logic [31:0] POLY_CRC16 = 32'h0000_8005;
   localparam logic [31:0] POLY_CRC32 = 32'h04C1_1DB7;

   localparam logic [31:0] MASK16      = 32'h0000_FFFF;
   localparam logic [31:0] MASK32      = 32'hFFFF_FFFF;
   localparam logic [31:0] RESET_VALUE = 32'h0000_FFFF;

   localparam int CTRL_W = 6;

   // Control register layout, bit 5 down to bit 0
   typedef struct packed {
      logic       inv_out;
      logic       rev_out;
      logic       inv_in;
      logic       rev_in;
      logic [1:0] poly_sel;
   } crc_ctrl_type;

   // Mirror a 32-bit word end for end
   function automatic logic [31:0] bit_reverse32(input logic [31:0] x);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) begin
         r[i] = x[31 - i];
      end
      return r;
   endfunction

   // CRC width mask for the selected polynomial
   function automatic logic [31:0] ctrl_poly_mask(input crc_ctrl_type ctrl);
      return ctrl.poly_sel[1] ? MASK32 : MASK16;
   endfunction

endpackage

>>> rtl/core/configurable_crc_engine.sv
// Each accepted request beat goes through the request register, then the response register.
// Throughput: one access per cycle unless responses stall; the CRC update for up to 32 data
// bits is one combinational XOR net between the request and the state/response registers.
// Reset (synchronous, active high): control 0, seed and running CRC 0xFFFF, both
// pipeline stages empty.
`include "configurable_crc_engine_defines.svh"

module configurable_crc_engine import cce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // address_offset[3:0], write_data[35:4], size_code[37:36]
   input  logic        req_tuser,  // mode
   // Response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // read_data[31:0]
   output logic        rsp_tuser,  // bad_offset
   // Control register write
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   logic         in_mode_ff;
   logic [3:0]   in_ofs_ff;
   logic [31:0]  in_data_ff;
   logic [1:0]   in_size_ff;

   logic         out_valid_ff, out_valid_in;
   logic [31:0]  out_data_ff, out_data_in;
   logic         out_bad_ff, out_bad_in;

   logic [CTRL_W-1:0] ctrl_ff;
   logic [31:0]  seed_ff, seed_in;
   logic [31:0]  crc_ff, crc_in;

   crc_ctrl_type ctrl;
   logic         req_fire;
   logic         advance;
   logic         exec;
   logic [31:0]  crc_updated;
   logic [31:0]  crc_readback;
   logic         seed_wr_exec;
   logic         data16_wr_exec;

   assign ctrl = crc_ctrl_type'(ctrl_ff);

   // Handshake: the compute stage moves when the response slot is free
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign exec       = in_valid_ff && advance;

   cce_crc_update u_update (
      .ctrl     (ctrl),
      .crc_cur  (crc_ff),
      .data     (in_data_ff),
      .size     (in_size_ff),
      .crc_next (crc_updated)
   );

   cce_crc_final u_final (
      .ctrl    (ctrl),
      .crc_cur (crc_ff),
      .crc_out (crc_readback)
   );

   // Access decode: state update, read mux, bad offset flag
   always_comb begin
      seed_in      = seed_ff;
      crc_in       = crc_ff;
      out_data_in  = 32'd0;
      out_bad_in   = !(in_ofs_ff == OFS_CTRL || in_ofs_ff == OFS_SEED ||
                       in_ofs_ff == OFS_DATA);
      if (in_mode_ff == MODE_WRITE) begin
         case (in_ofs_ff)
            OFS_SEED: begin
               seed_in = in_data_ff;
               crc_in  = in_data_ff;
            end
            OFS_DATA: crc_in = crc_updated;
            default:  crc_in = crc_ff;
         endcase
      end else begin
         case (in_ofs_ff)
            OFS_CTRL: out_data_in = {{(32-CTRL_W){1'b0}}, ctrl_ff};
            OFS_SEED: out_data_in = seed_ff;
            OFS_DATA: out_data_in = crc_readback;
            default:  out_data_in = 32'd0;
         endcase
      end
   end

   // Stage valid flags
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (exec) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (exec) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctrl_ff      <= '0;
         seed_ff      <= RESET_VALUE;
         crc_ff       <= RESET_VALUE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            ctrl_ff <= csr_wdata;
         end
         if (exec) begin
            seed_ff <= seed_in;
            crc_ff  <= crc_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff <= req_tuser;
         in_ofs_ff  <= req_tdata[3:0];
         in_data_ff <= req_tdata[35:4];
         in_size_ff <= req_tdata[37:36];
      end
      if (exec) begin
         out_data_ff <= out_data_in;
         out_bad_ff  <= out_bad_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_bad_ff;

   // Checks
   assign seed_wr_exec   = exec && in_mode_ff == MODE_WRITE && in_ofs_ff == OFS_SEED;
   assign data16_wr_exec = exec && in_mode_ff == MODE_WRITE && in_ofs_ff == OFS_DATA &&
                           !ctrl.poly_sel[1];

   `CCE_ASSERT_ALWAYS(a_rst_empty, $past(reset) |-> !rsp_tvalid && req_tready, "busy after reset")
   `CCE_ASSERT(a_bad_reads_zero, rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0, "bad beat has data")
   `CCE_ASSERT(a_seed_reload, seed_wr_exec |=> crc_ff == seed_ff, "seed write did not reload CRC")
   `CCE_ASSERT(a_crc16_width, data16_wr_exec |=> crc_ff[31:16] == 16'd0, "16-bit CRC too wide")

endmodule

>>> rtl/core/cce_crc_update.sv
module cce_crc_update import cce_pkg::*; (
   input  crc_ctrl_type ctrl,
   input  logic [31:0]  crc_cur,
   input  logic [31:0]  data,
   input  logic [1:0]   size,
   output logic [31:0]  crc_next
);

   logic [31:0] dmask;
   logic [5:0]  nbits;
   logic [31:0] poly;
   logic [31:0] cmask;
   logic [31:0] val_masked;
   logic [31:0] val_rev;
   logic [31:0] val_final;

   // Access width decode
   always_comb begin
      case (size)
         SIZE_BYTE: begin
            dmask = 32'h0000_00FF;
            nbits = 6'd8;
         end
         SIZE_HALF: begin
            dmask = 32'h0000_FFFF;
            nbits = 6'd16;
         end
         default: begin
            dmask = MASK32;
            nbits = 6'd32;
         end
      endcase
   end

   // Polynomial decode
   always_comb begin
      case (ctrl.poly_sel)
         POLY_SEL_CCITT: poly = POLY_CCITT;
         POLY_SEL_CRC16: poly = POLY_CRC16;
         default:        poly = POLY_CRC32;
      endcase
   end

   assign cmask = ctrl_poly_mask(ctrl);

   // Mask, optional reverse within the access width, optional complement
   always_comb begin
      val_masked = data & dmask;
      val_rev    = bit_reverse32(val_masked);
      case (size)
         SIZE_BYTE: val_rev = val_rev >> 24;
         SIZE_HALF: val_rev = val_rev >> 16;
         default:   val_rev = val_rev;
      endcase
      val_final = ctrl.rev_in ? val_rev : val_masked;
      if (ctrl.inv_in) begin
         val_final = val_final ^ dmask;
      end
   end

   // Bitwise shift-left CRC, MSB of the access first; flattens to an XOR net
   always_comb begin
      logic [31:0] c;
      logic        fb;
      c  = crc_cur & cmask;
      fb = 1'b0;
      for (int i = 31; i >= 0; i--) begin
         if (6'(i) < nbits) begin
            fb = (ctrl.poly_sel[1] ? c[31] : c[15]) ^ val_final[i];
            c  = (c << 1) & cmask;
            if (fb) begin
               c = c ^ poly;
            end
         end
      end
      crc_next = c;
   end

endmodule

>>> rtl/core/cce_crc_final.sv
module cce_crc_final import cce_pkg::*; (
   input  crc_ctrl_type ctrl,
   input  logic [31:0]  crc_cur,
   output logic [31:0]  crc_out
);

   logic [31:0] cmask;
   logic [31:0] crc_masked;
   logic [31:0] crc_rev;

   assign cmask      = ctrl_poly_mask(ctrl);
   assign crc_masked = crc_cur & cmask;

   // Reverse within the CRC width
   always_comb begin
      crc_rev = bit_reverse32(crc_masked);
      if (!ctrl.poly_sel[1]) begin
         crc_rev = crc_rev >> 16;
      end
   end

   // Optional reverse, then optional complement
   always_comb begin
      crc_out = ctrl.rev_out ? crc_rev : crc_masked;
      if (ctrl.inv_out) begin
         crc_out = crc_out ^ cmask;
      end
   end

endmodule

>>> dv/tb_top.sv
import cce_pkg::*;

// Polynomial selects and the size code that have no name in the package
localparam logic [1:0] POLY_SEL_CRC32 = 2'd2;
localparam logic [1:0] POLY_SEL_ALT32 = 2'd3;
localparam logic [1:0] SIZE_ALT_WORD  = 2'd3;

typedef struct packed {
   logic [31:0] read_data;
   logic        bad_offset;
} crc_response_type;

// Tracks control, seed and running CRC, and queues the response each access should give
class crc_access_scoreboard;
   crc_ctrl_type     ctrl;
   logic [31:0]      seed;
   logic [31:0]      crc;
   crc_response_type awaited_responses[$];
   int               errors;

   function new();
      ctrl   = '0;
      seed   = RESET_VALUE;
      crc    = RESET_VALUE;
      errors = 0;
   endfunction

   function void set_control(input logic [5:0] value);
      ctrl = crc_ctrl_type'(value);
   endfunction

   function int pending();
      return awaited_responses.size();
   endfunction

   function logic [31:0] mirror(input logic [31:0] x, input int w);
      logic [31:0] r = '0;
      for (int i = 0; i < w; i++) begin
         if (x[i]) r[w - 1 - i] = 1'b1;
      end
      return r;
   endfunction

   function int poly_nbits();
      return ctrl.poly_sel[1] ? 32 : 16;
   endfunction

   function logic [31:0] crc_mask();
      return ctrl.poly_sel[1] ? 32'hFFFF_FFFF : 32'h0000_FFFF;
   endfunction

   // Shift one data write into the running CRC, MSB first
   function void crc_feed(input logic [31:0] data, input logic [1:0] size);
      int          nbits;
      int          w;
      logic [31:0] dmask;
      logic [31:0] poly;
      logic [31:0] c;
      logic        top;
      nbits = (size == SIZE_BYTE) ? 8 : (size == SIZE_HALF) ? 16 : 32;
      dmask = (nbits == 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 32'd1);
      w     = poly_nbits();
      case (ctrl.poly_sel)
         POLY_SEL_CCITT: poly = POLY_CCITT;
         POLY_SEL_CRC16: poly = POLY_CRC16;
         default:        poly = POLY_CRC32;
      endcase
      data &= dmask;
      if (ctrl.rev_in) data = mirror(data, nbits);
      if (ctrl.inv_in) data ^= dmask;
      c = crc & crc_mask();
      for (int i = nbits - 1; i >= 0; i--) begin
         top = c[w - 1];
         c   = (c << 1) & crc_mask();
         if (top ^ data[i]) c ^= poly;
      end
      crc = c;
   endfunction

   function logic [31:0] crc_readout();
      logic [31:0] r;
      r = crc & crc_mask();
      if (ctrl.rev_out) r = mirror(r, poly_nbits());
      if (ctrl.inv_out) r ^= crc_mask();
      return r;
   endfunction

   // Accepted request beat: update state and queue its response
   function void note_request(input logic mode, input logic [3:0] ofs,
                              input logic [31:0] data, input logic [1:0] size);
      crc_response_type r;
      r.read_data  = '0;
      r.bad_offset = !(ofs == OFS_CTRL || ofs == OFS_SEED || ofs == OFS_DATA);
      if (mode == MODE_WRITE) begin
         if (ofs == OFS_SEED) begin
            seed = data;
            crc  = data;
         end else if (ofs == OFS_DATA) begin
            crc_feed(data, size);
         end
      end else begin
         if (ofs == OFS_CTRL) r.read_data = {26'd0, ctrl};
         else if (ofs == OFS_SEED) r.read_data = seed;
         else if (ofs == OFS_DATA) r.read_data = crc_readout();
      end
      awaited_responses.push_back(r);
   endfunction

   task report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task check_response(input logic [31:0] read_data, input logic bad_offset);
      crc_response_type e;
      if (awaited_responses.size() == 0) begin
         report($sformatf("response beat with none awaited (data %h bad %b)",
                          read_data, bad_offset));
      end else begin
         e = awaited_responses.pop_front();
         if (read_data !== e.read_data)
            report($sformatf("read_data %h, expected %h", read_data, e.read_data));
         if (bad_offset !== e.bad_offset)
            report($sformatf("bad_offset %b, expected %b", bad_offset, e.bad_offset));
      end
   endtask
endclass

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 2000;  // cycles with no beat before giving up
   localparam int SETTLE       = 4;     // extra wait once all responses have drained
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 50;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // address_offset[3:0], write_data[35:4], size_code[37:36]
   logic        req_tuser = 1'b0; // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // read_data[31:0]
   logic        rsp_tuser;        // bad_offset
   logic        csr_we = 1'b0;
   logic [5:0]  csr_wdata = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_armed    = 1'b0;

   crc_access_scoreboard sb = new();

   configurable_crc_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Beat monitors on both channels
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tuser, req_tdata[3:0], req_tdata[35:4], req_tdata[37:36]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
   end

   // Receiver: random stalls, or one long hold-off when armed
   initial begin
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_armed = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog on cycles without any beat
   initial begin
      int quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   // Offer one access and wait for its request beat; valid stays up afterwards
   task automatic send_access(input logic mode, input logic [3:0] ofs,
                              input logic [31:0] data, input logic [1:0] size);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {2'b00, size, data, ofs};
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic read_reg(input logic [3:0] ofs);
      send_access(MODE_READ, ofs, $urandom, 2'($urandom_range(3)));
   endtask

   task automatic write_reg(input logic [3:0] ofs, input logic [31:0] data,
                            input logic [1:0] size);
      send_access(MODE_WRITE, ofs, data, size);
   endtask

   // Let all responses drain, then write the control register
   task automatic write_control(input logic [5:0] value);
      req_tvalid <= 1'b0;
      // let the monitor log the last request beat before checking the queue
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_control(value);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return RESET_VALUE;
         default: return $urandom;
      endcase
   endfunction

   // Mostly seed / data / read-back runs, the rest arbitrary accesses
   task automatic random_traffic(inout int count);
      int n;
      if ($urandom_range(99) < 75) begin
         n = $urandom_range(6);
         if ($urandom_range(3) != 0) begin
            write_reg(OFS_SEED, pick_word(), 2'($urandom_range(3)));
            count++;
         end
         repeat (n) begin
            write_reg(OFS_DATA, pick_word(), 2'($urandom_range(3)));
            count++;
         end
         read_reg(OFS_DATA);
         count++;
      end else begin
         case ($urandom_range(4))
            0: read_reg(OFS_SEED);
            1: read_reg(OFS_CTRL);
            2: write_reg(OFS_CTRL, pick_word(), 2'($urandom_range(3)));
            default: send_access(1'($urandom_range(1)), 4'($urandom_range(15)),
                                 pick_word(), 2'($urandom_range(3)));
         endcase
         count++;
      end
   endtask

   initial begin
      logic [5:0] phase_ctrl [PHASES];
      int         count;

      phase_ctrl[0] = 6'h00;
      phase_ctrl[1] = 6'h3F;
      phase_ctrl[2] = {4'b0000, POLY_SEL_CRC16};
      phase_ctrl[3] = {4'b0101, POLY_SEL_CRC32};
      for (int p = 4; p < PHASES; p++) phase_ctrl[p] = 6'($urandom_range(63));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset values, ignored control write, bad offsets, masking
      read_reg(OFS_CTRL);
      read_reg(OFS_SEED);
      read_reg(OFS_DATA);
      write_reg(OFS_CTRL, 32'hFFFF_FFFF, SIZE_WORD);
      read_reg(OFS_CTRL);
      write_reg(4'd1, 32'hFFFF_FFFF, SIZE_WORD);
      read_reg(4'd15);
      send_access(MODE_WRITE, 4'd12, 32'h1234_5678, SIZE_ALT_WORD);
      write_reg(OFS_DATA, 32'h0000_0000, SIZE_BYTE);
      write_reg(OFS_DATA, 32'hFFFF_FFFF, SIZE_HALF);
      write_reg(OFS_DATA, 32'hFFFF_FFFF, SIZE_WORD);
      write_reg(OFS_DATA, 32'hFFFF_FF31, SIZE_BYTE);
      write_reg(OFS_DATA, 32'h8765_4321, SIZE_ALT_WORD);
      read_reg(OFS_DATA);
      write_reg(OFS_SEED, 32'hFFFF_FFFF, SIZE_WORD);
      read_reg(OFS_SEED);
      read_reg(OFS_DATA);
      write_reg(OFS_SEED, 32'h0000_0000, SIZE_BYTE);
      read_reg(OFS_DATA);

      // Directed: all options on, then select three, then reflected input
      write_control(6'h3F);
      write_reg(OFS_SEED, 32'hFFFF_FFFF, SIZE_WORD);
      write_reg(OFS_DATA, 32'hA5C3_0F81, SIZE_WORD);
      read_reg(OFS_DATA);
      read_reg(OFS_CTRL);
      write_control({4'b0000, POLY_SEL_ALT32});
      write_reg(OFS_DATA, 32'h0000_BEEF, SIZE_HALF);
      read_reg(OFS_DATA);
      write_control({4'b0001, POLY_SEL_CRC16});
      write_reg(OFS_DATA, 32'h0000_0080, SIZE_BYTE);
      read_reg(OFS_DATA);

      // Random phases, cycling the idle pattern
      for (int p = 0; p < PHASES; p++) begin
         write_control(phase_ctrl[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 62; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 62; end
            default: begin send_idle_pct = 34; rsp_stall_pct = 34; end
         endcase
         // back-pressure: receiver holds off while the sender keeps going
         if (p == 4) hold_armed = 1'b1;
         count = 0;
         while (count < PHASE_ITEMS) random_traffic(count);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> configurable_crc_engine.f
+incdir+rtl/core
rtl/core/cce_pkg.sv
rtl/core/cce_crc_update.sv
rtl/core/cce_crc_final.sv
rtl/core/configurable_crc_engine.sv
dv/tb_top.sv
